// ===== rtl/b64r_pkg.sv =====
package b64r_pkg;

  localparam int RING_W      = 17;
  localparam int STEP_W      = 5;
  localparam int POS_OUT_W   = 16;
  localparam int CHAR_W      = 8;
  localparam int SKIP_W      = 16;
  localparam int SYM_W       = 6;
  localparam int REQ_W       = 2;
  localparam int KIND_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CMD_DATA_W  = 3 * BYTE_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_BITS_DEFAULT = 16;

  localparam logic [RING_W-1:0] RING_SIZE_RESET = RING_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_MIN = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_BEGIN = 2'd0,
    REQ_CHAR  = 2'd1,
    REQ_QUOTE = 2'd2,
    REQ_FLUSH = 2'd3
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CHUNK = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_GROUP  = 2'd1,
    OP_ERROR  = 2'd2,
    OP_REPORT = 2'd3
  } op_t;

  // data holds the three decoded bytes (first byte on top) or the skip count
  typedef struct packed {
    op_t                   op;
    logic                  last;
    logic [1:0]            nbytes;
    logic [CMD_DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [RING_W-1:0] ring_size;
    logic [STEP_W-1:0] step_log2;
    logic [RING_W-1:0] chunk_minimum;
  } cfg_t;

endpackage

// ===== rtl/b64r_front.sv =====
module b64r_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [b64r_pkg::REQ_W-1:0]    req_type,
  input  logic [b64r_pkg::CHAR_W-1:0]   char_code,
  input  logic [b64r_pkg::SKIP_W-1:0]   skip_count,
  input  logic                          queue_full,
  output logic                          push,
  output b64r_pkg::cmd_t                cmd
);
  import b64r_pkg::*;

  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_PAD     = 8'h3D;

  logic [SYM_W-1:0] symbol_group [4];
  logic [1:0]       symbol_count, symbol_count_next;
  logic [1:0]       pad_offset, pad_offset_next;
  logic             error_seen, error_seen_next;

  logic             accept;
  logic             is_pad;
  logic             sym_ok;
  logic [SYM_W-1:0] sym_val;
  logic [1:0]       pad_upd;
  logic [1:0]       group_bytes;
  logic             group_we;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign is_pad   = (char_code == CH_PAD);
  assign pad_upd  = is_pad ? 2'(pad_offset + 2'd1) : pad_offset;

  always_comb begin
    sym_ok  = 1'b1;
    sym_val = '0;
    if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
      sym_val = SYM_W'(char_code - CH_UPPER_A);
    end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
      sym_val = SYM_W'(char_code - CH_LOWER_A + 8'd26);
    end else if (char_code >= CH_DIGIT_0 && char_code <= CH_DIGIT_9) begin
      sym_val = SYM_W'(char_code - CH_DIGIT_0 + 8'd52);
    end else if (char_code == CH_PLUS) begin
      sym_val = 6'd62;
    end else if (char_code == CH_SLASH) begin
      sym_val = 6'd63;
    end else if (!is_pad) begin
      sym_ok = 1'b0;
    end
  end

  // padding marks drop bytes from the end of the group
  always_comb begin
    unique case (pad_upd)
      2'd0:    group_bytes = 2'd3;
      2'd1:    group_bytes = 2'd3;
      2'd2:    group_bytes = 2'd2;
      default: group_bytes = 2'd1;
    endcase
  end

  always_comb begin
    push              = 1'b0;
    cmd.op            = OP_BEGIN;
    cmd.last          = 1'b0;
    cmd.nbytes        = '0;
    cmd.data          = '0;
    symbol_count_next = symbol_count;
    pad_offset_next   = pad_offset;
    error_seen_next   = error_seen;
    group_we          = 1'b0;
    if (accept) begin
      unique case (req_t'(req_type))
        REQ_BEGIN: begin
          push              = 1'b1;
          cmd.op            = OP_BEGIN;
          cmd.data          = CMD_DATA_W'(skip_count);
          symbol_count_next = '0;
          pad_offset_next   = 2'd1;
          error_seen_next   = 1'b0;
        end
        REQ_CHAR: begin
          if (!error_seen) begin
            if (!sym_ok || (is_pad && symbol_count < 2'd2)) begin
              push            = 1'b1;
              cmd.op          = OP_ERROR;
              error_seen_next = 1'b1;
            end else if (symbol_count == 2'd3) begin
              push              = 1'b1;
              cmd.op            = OP_GROUP;
              cmd.nbytes        = group_bytes;
              cmd.data          = {symbol_group[0], symbol_group[1],
                                   symbol_group[2], sym_val};
              symbol_count_next = '0;
              pad_offset_next   = 2'd1;
            end else begin
              group_we          = 1'b1;
              symbol_count_next = 2'(symbol_count + 2'd1);
              pad_offset_next   = pad_upd;
            end
          end
        end
        REQ_QUOTE: begin
          if (!error_seen) begin
            push = 1'b1;
            if (symbol_count != 2'd0) begin
              cmd.op          = OP_ERROR;
              error_seen_next = 1'b1;
            end else begin
              cmd.op   = OP_REPORT;
              cmd.last = 1'b1;
            end
          end
        end
        REQ_FLUSH: begin
          if (!error_seen) begin
            push   = 1'b1;
            cmd.op = OP_REPORT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      pad_offset   <= 2'd1;
      error_seen   <= 1'b0;
    end else begin
      symbol_count <= symbol_count_next;
      pad_offset   <= pad_offset_next;
      error_seen   <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (group_we) begin
      symbol_group[symbol_count] <= sym_val;
    end
  end

endmodule

// ===== rtl/b64r_queue.sv =====
module b64r_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64r_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output b64r_pkg::cmd_t head
);
  import b64r_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("command popped from an empty queue");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above its depth");
`endif

endmodule

// ===== rtl/b64r_back.sv =====
module b64r_back #(
  parameter int ADDR_BITS = b64r_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  b64r_pkg::cfg_t                   cfg,
  input  logic                             head_valid,
  input  b64r_pkg::cmd_t                   head,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [b64r_pkg::KIND_W-1:0]      kind,
  output logic [b64r_pkg::POS_OUT_W-1:0]   position,
  output logic [b64r_pkg::BYTE_W-1:0]      data_byte,
  output logic [b64r_pkg::RING_W-1:0]      chunk_size,
  output logic                             last_result
);
  import b64r_pkg::*;

  localparam int POS_W = (ADDR_BITS + 1 < RING_W) ? ADDR_BITS + 1 : RING_W;
  localparam int EFF_W = (ADDR_BITS + 1 > RING_W) ? ADDR_BITS + 1 : RING_W;

  logic [SKIP_W-1:0] skip_left, skip_left_next;
  logic [POS_W-1:0]  write_pos, write_pos_next;
  logic [POS_W-1:0]  chunk_start, chunk_start_next;
  logic [1:0]        step, step_next;

  // decisions of a report, taken in its first step
  logic              rpt_wrap;
  logic              rpt_emit2;
  logic [POS_W-1:0]  rpt_tail;
  logic [POS_W-1:0]  rpt_size;
  logic              rpt_load;

  logic [EFF_W-1:0]  ring_wide;
  logic [EFF_W-1:0]  ring_top;
  logic [EFF_W-1:0]  eff_wide;
  logic [POS_W-1:0]  eff;

  logic              adv, go, done;
  logic              emit;
  kind_t             emit_kind;
  logic [POS_W-1:0]  emit_pos;
  logic [BYTE_W-1:0] emit_byte;
  logic [POS_W-1:0]  emit_size;
  logic              emit_last;

  logic [BYTE_W-1:0] cur_byte;
  logic [POS_W-1:0]  wp_cur;
  logic              wrap_calc;
  logic [POS_W-1:0]  raw_size;
  logic [POS_W-1:0]  keep_mask;
  logic [POS_W-1:0]  rounded;
  logic              emit2_calc;
  logic [POS_W-1:0]  tail_calc;

  // ring size clamped to 1 .. 2^ADDR_BITS
  assign ring_wide = EFF_W'(cfg.ring_size);
  assign ring_top  = EFF_W'(1) << ADDR_BITS;
  always_comb begin
    if (ring_wide == '0) begin
      eff_wide = EFF_W'(1);
    end else if (ring_wide > ring_top) begin
      eff_wide = ring_top;
    end else begin
      eff_wide = ring_wide;
    end
  end
  assign eff = POS_W'(eff_wide);

  assign adv = !out_valid || !out_stall;
  assign go  = adv && head_valid;

  always_comb begin
    unique case (step)
      2'd0:    cur_byte = head.data[3*BYTE_W-1:2*BYTE_W];
      2'd1:    cur_byte = head.data[2*BYTE_W-1:BYTE_W];
      default: cur_byte = head.data[BYTE_W-1:0];
    endcase
  end

  assign wp_cur     = (write_pos >= eff) ? '0 : write_pos;
  assign wrap_calc  = (chunk_start > write_pos);
  assign raw_size   = wrap_calc ? write_pos : POS_W'(write_pos - chunk_start);
  assign keep_mask  = {POS_W{1'b1}} << cfg.step_log2;
  assign rounded    = raw_size & keep_mask;
  assign emit2_calc = head.last || (RING_W'(rounded) >= cfg.chunk_minimum);
  assign tail_calc  = (eff > chunk_start) ? POS_W'(eff - chunk_start) : '0;

  always_comb begin
    emit             = 1'b0;
    emit_kind        = KIND_BYTE;
    emit_pos         = '0;
    emit_byte        = '0;
    emit_size        = '0;
    emit_last        = 1'b0;
    done             = 1'b0;
    rpt_load         = 1'b0;
    step_next        = step;
    skip_left_next   = skip_left;
    write_pos_next   = write_pos;
    chunk_start_next = chunk_start;
    if (go) begin
      unique case (head.op)
        OP_BEGIN: begin
          skip_left_next = head.data[SKIP_W-1:0];
          done           = 1'b1;
        end
        OP_ERROR: begin
          emit      = 1'b1;
          emit_kind = KIND_ERROR;
          emit_last = 1'b1;
          done      = 1'b1;
        end
        OP_GROUP: begin
          done = (step == 2'(head.nbytes - 2'd1));
          if (skip_left != '0) begin
            skip_left_next = SKIP_W'(skip_left - 1'b1);
          end else begin
            emit           = 1'b1;
            emit_kind      = KIND_BYTE;
            emit_pos       = wp_cur;
            emit_byte      = cur_byte;
            emit_last      = done;
            write_pos_next = POS_W'(wp_cur + 1'b1);
          end
          if (!done) begin
            step_next = 2'(step + 2'd1);
          end
        end
        OP_REPORT: begin
          unique case (step)
            2'd0: begin
              rpt_load = 1'b1;
              if (wrap_calc) begin
                step_next = 2'd1;
              end else if (emit2_calc) begin
                step_next = 2'd2;
              end else begin
                done = 1'b1;
              end
            end
            2'd1: begin
              // tail from chunk start up to the ring end
              emit             = 1'b1;
              emit_kind        = KIND_CHUNK;
              emit_pos         = chunk_start;
              emit_size        = rpt_tail;
              emit_last        = !rpt_emit2;
              chunk_start_next = '0;
              if (rpt_emit2) begin
                step_next = 2'd2;
              end else begin
                done = 1'b1;
              end
            end
            default: begin
              emit             = 1'b1;
              emit_kind        = KIND_CHUNK;
              emit_pos         = chunk_start;
              emit_size        = rpt_size;
              emit_last        = 1'b1;
              chunk_start_next = POS_W'(chunk_start + rpt_size);
              done             = 1'b1;
            end
          endcase
        end
      endcase
      if (done) begin
        step_next = '0;
      end
    end
  end

  assign pop = go && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_left   <= '0;
      write_pos   <= '0;
      chunk_start <= '0;
      step        <= '0;
      out_valid   <= 1'b0;
    end else begin
      skip_left   <= skip_left_next;
      write_pos   <= write_pos_next;
      chunk_start <= chunk_start_next;
      step        <= step_next;
      if (adv) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rpt_load) begin
      rpt_wrap  <= wrap_calc;
      rpt_emit2 <= emit2_calc;
      rpt_tail  <= tail_calc;
      rpt_size  <= rounded;
    end
    if (adv && emit) begin
      kind        <= emit_kind;
      position    <= POS_OUT_W'(emit_pos);
      data_byte   <= emit_byte;
      chunk_size  <= RING_W'(emit_size);
      last_result <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_step_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    step != 2'd0 |-> head_valid)
    else $error("sequencer mid command with empty queue");

  a_group_step_range: assert property (@(posedge clk) disable iff (rst)
    head_valid && head.op == OP_GROUP |-> step < head.nbytes)
    else $error("group step past its byte count");

  a_tail_only_on_wrap: assert property (@(posedge clk) disable iff (rst)
    go && head.op == OP_REPORT && step == 2'd1 |-> rpt_wrap)
    else $error("tail chunk sent without wrapped chunk start");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> position == '0 && chunk_size == '0 && last_result)
    else $error("malformed error transfer");

  a_skip_holds_pos: assert property (@(posedge clk) disable iff (rst)
    go && head.op == OP_GROUP && skip_left != '0 |=> write_pos == $past(write_pos))
    else $error("write position moved on a skipped byte");
`endif

endmodule

// ===== rtl/base64_ring_decoder.sv =====
// path: a transfer is queued, then the back end registers the result; reports first decide
// throughput: one item per cycle into a 4-entry command queue while in_stall is low; the back end
//   takes one step per decoded byte (written or skipped), per begin and per error, plus a decision
//   step and a step per chunk on each report, and holds while out_stall holds a valid result
// reset: synchronous active-high rst clears decode state, ring pointers and the queue;
//   configuration returns to ring size 65536, step 0, chunk minimum 0
module base64_ring_decoder #(
  parameter int ADDR_BITS = b64r_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [b64r_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [b64r_pkg::RING_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [b64r_pkg::REQ_W-1:0]       req_type,
  input  logic [b64r_pkg::CHAR_W-1:0]      char_code,
  input  logic [b64r_pkg::SKIP_W-1:0]      skip_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [b64r_pkg::KIND_W-1:0]      kind,
  output logic [b64r_pkg::POS_OUT_W-1:0]   position,
  output logic [b64r_pkg::BYTE_W-1:0]      data_byte,
  output logic [b64r_pkg::RING_W-1:0]      chunk_size,
  output logic                             last_result
);
  import b64r_pkg::*;

  cfg_t cfg;
  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic pop;
  logic head_valid;
  cmd_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_size     <= RING_SIZE_RESET;
      cfg.step_log2     <= '0;
      cfg.chunk_minimum <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RING_SIZE: cfg.ring_size     <= cfg_data;
        CFG_STEP_LOG2: cfg.step_log2     <= cfg_data[STEP_W-1:0];
        CFG_CHUNK_MIN: cfg.chunk_minimum <= cfg_data;
        default: ;
      endcase
    end
  end

  b64r_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .char_code  (char_code),
    .skip_count (skip_count),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  b64r_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  b64r_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .position    (position),
    .data_byte   (data_byte),
    .chunk_size  (chunk_size),
    .last_result (last_result)
  );

endmodule
